// ===== sv/vector_length_clamp_macros.svh =====
// Assertion macros used by the vector length clamp back end (vlc_back)
`ifndef VECTOR_LENGTH_CLAMP_MACROS_SVH
`define VECTOR_LENGTH_CLAMP_MACROS_SVH

// Property that holds at every clock edge outside reset
`define VLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at the next edge
`define VLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vlc_pkg.sv =====
package vlc_pkg;

  localparam int CW = 16;
  localparam int FB = 8;
  localparam int OW = CW + 1;
  localparam int SQW = 2 * CW;
  localparam int PW = 2 * CW;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef enum logic [1:0] {
    CMD_LENGTH = 2'd0,
    CMD_NORM   = 2'd1,
    CMD_CLAMP  = 2'd2,
    CMD_SCALE  = 2'd3
  } cmd_t;

  // Classified item passed from front to back
  typedef struct packed {
    cmd_t             cmd;
    logic             nx;
    logic             ny;
    logic [CW-1:0]    ax;
    logic [CW-1:0]    ay;
    logic [CW-1:0]    amt;
    logic [SQW:0]     sq;
  } front_item_t;

  // Saturating signed pack of a magnitude to the output width
  function automatic logic [OW-1:0] pack_out(input logic neg, input logic [PW-1:0] mag);
    logic [OW-1:0] m;
    m = (mag > PW'((64'd1 << CW) - 1)) ? OW'((64'd1 << CW) - 1) : mag[OW-1:0];
    return neg ? (OW'(0) - m) : m;
  endfunction

endpackage

// ===== sv/vector_length_clamp.sv =====
// Channel | Ports                                  | Direction
// in      | in_valid/in_ready, command, vec, amount | input
// out     | out_valid/out_ready, x, y, length, flag | output
// One item per cycle sustained while out_ready is high; a result passes the classify register,
// the queue, root stage load, 16 square root stages (one root bit each), products, 32 divider
// stages (one quotient bit each) and the output register.
// Synchronous active-low reset clears valid flags, queue pointers and fill count only.
// A stalled result holds the back pipe; the 4-entry queue absorbs front beats.
module vector_length_clamp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_command,
  input  logic signed [vlc_pkg::CW-1:0] in_vec_x,
  input  logic signed [vlc_pkg::CW-1:0] in_vec_y,
  input  logic [vlc_pkg::CW-1:0]     in_amount,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [vlc_pkg::OW-1:0] out_x,
  output logic signed [vlc_pkg::OW-1:0] out_y,
  output logic [vlc_pkg::CW-1:0]     out_length,
  output logic                       out_was_clamped
);

  logic f_valid, f_ready, q_valid, q_ready;
  vlc_pkg::front_item_t f_item, q_item;

  vlc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_vec_x, .in_vec_y,
    .in_amount, .f_valid, .f_ready, .f_item
  );

  vlc_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  vlc_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .out_x, .out_y, .out_length, .out_was_clamped
  );

endmodule

// ===== sv/vlc_front.sv =====
module vlc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic signed [vlc_pkg::CW-1:0] in_vec_x,
  input  logic signed [vlc_pkg::CW-1:0] in_vec_y,
  input  logic [vlc_pkg::CW-1:0]    in_amount,
  output logic                      f_valid,
  input  logic                      f_ready,
  output vlc_pkg::front_item_t      f_item
);

  logic                 v_r;
  vlc_pkg::front_item_t it_r;
  logic [vlc_pkg::CW-1:0] ax, ay;
  logic [vlc_pkg::SQW-1:0] px, py;

  assign ax = in_vec_x[vlc_pkg::CW-1] ? (vlc_pkg::CW'(0) - in_vec_x) : in_vec_x;
  assign ay = in_vec_y[vlc_pkg::CW-1] ? (vlc_pkg::CW'(0) - in_vec_y) : in_vec_y;
  assign px = ax * ax;
  assign py = ay * ay;

  assign in_ready = !v_r || f_ready;
  assign f_valid  = v_r;
  assign f_item   = it_r;

  // Valid flag of the classify register
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  // Sign split and square sum
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_r.cmd   <= vlc_pkg::cmd_t'(in_command);
      it_r.nx    <= in_vec_x[vlc_pkg::CW-1];
      it_r.ny    <= in_vec_y[vlc_pkg::CW-1];
      it_r.ax    <= ax;
      it_r.ay    <= ay;
      it_r.amt   <= in_amount;
      it_r.sq    <= {1'b0, px} + {1'b0, py};
    end
  end

endmodule

// ===== sv/vlc_queue.sv =====
module vlc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  vlc_pkg::front_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output vlc_pkg::front_item_t rd_item
);

  vlc_pkg::front_item_t mem_r [vlc_pkg::QDEPTH];
  logic [vlc_pkg::QAW-1:0] wp_r, rp_r;
  logic [vlc_pkg::QAW:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (vlc_pkg::QAW+1)'(vlc_pkg::QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (vlc_pkg::QAW+1)'(wr) - (vlc_pkg::QAW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
  end

endmodule

// ===== sv/vlc_back.sv =====
`include "vector_length_clamp_macros.svh"
module vlc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  vlc_pkg::front_item_t q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [vlc_pkg::OW-1:0] out_x,
  output logic [vlc_pkg::OW-1:0] out_y,
  output logic [vlc_pkg::CW-1:0] out_length,
  output logic                 out_was_clamped
);

  localparam int NS = vlc_pkg::CW;      // sqrt stages, one root bit each
  localparam int NQ = vlc_pkg::PW;      // divide stages, one quotient bit each
  localparam int NT = NS + 1 + NQ + 2;  // total pipeline depth
  localparam int RW = vlc_pkg::CW + 1;  // sqrt remainder extra headroom

  typedef struct packed {
    vlc_pkg::front_item_t it;
    logic [vlc_pkg::SQW:0]  rem;
    logic [vlc_pkg::CW-1:0] root;
  } sq_stage_t;

  typedef struct packed {
    vlc_pkg::front_item_t   it;
    logic [vlc_pkg::CW-1:0] len;
    logic                   div;
    logic                   clamp;
    logic [vlc_pkg::PW-1:0] nx_q;
    logic [vlc_pkg::PW-1:0] ny_q;
    logic [vlc_pkg::CW:0]   rx;
    logic [vlc_pkg::CW:0]   ry;
  } dv_stage_t;

  logic      adv;
  logic [NT-1:0] v_r;
  sq_stage_t s_r [NS+1];
  dv_stage_t d_r [NQ+1];
  logic [vlc_pkg::OW-1:0] ox_r, oy_r;
  logic [vlc_pkg::CW-1:0] ol_r;
  logic                   oc_r;

  // Whole pipe moves as one; output register is the last stage
  assign adv     = !v_r[NT-1] || out_ready;
  assign q_ready = adv;
  assign out_valid       = v_r[NT-1];
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_length      = ol_r;
  assign out_was_clamped = oc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NT-2:0], q_valid};
  end

  // Square root: one root bit per stage, restoring
  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0].it   <= q_item;
      s_r[0].rem  <= q_item.sq;
      s_r[0].root <= '0;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    logic [vlc_pkg::SQW:0] trial;
    assign trial = ((vlc_pkg::SQW+1)'({s_r[g].root, 1'b0}) << (NS-1-g))
                 | ((vlc_pkg::SQW+1)'(1) << (2*(NS-1-g)));
    always_ff @(posedge clk) begin
      if (adv) begin
        s_r[g+1].it <= s_r[g].it;
        if (s_r[g].rem >= trial) begin
          s_r[g+1].rem  <= s_r[g].rem - trial;
          s_r[g+1].root <= s_r[g].root | (vlc_pkg::CW'(1) << (NS-1-g));
        end else begin
          s_r[g+1].rem  <= s_r[g].rem;
          s_r[g+1].root <= s_r[g].root;
        end
      end
    end
  end

  // Classify and form products
  logic [vlc_pkg::PW-1:0] pax, pay;
  logic [vlc_pkg::CW-1:0] slen;
  logic                   zero, sdiv, sclamp;
  assign slen   = s_r[NS].root;
  assign zero   = slen == '0;
  assign pax    = s_r[NS].it.ax * s_r[NS].it.amt;
  assign pay    = s_r[NS].it.ay * s_r[NS].it.amt;
  assign sclamp = s_r[NS].it.cmd == vlc_pkg::CMD_CLAMP && s_r[NS].it.amt < slen;
  assign sdiv   = !zero && (s_r[NS].it.cmd == vlc_pkg::CMD_NORM || sclamp);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0].it    <= s_r[NS].it;
      d_r[0].len   <= slen;
      d_r[0].div   <= sdiv;
      d_r[0].clamp <= sclamp;
      d_r[0].nx_q  <= pax;
      d_r[0].ny_q  <= pay;
      d_r[0].rx    <= '0;
      d_r[0].ry    <= '0;
    end
  end

  // Restoring division: one quotient bit per stage, both lanes
  for (genvar g = 0; g < NQ; g++) begin : g_div
    logic [vlc_pkg::CW:0] tx, ty;
    assign tx = {d_r[g].rx[vlc_pkg::CW-1:0], d_r[g].nx_q[vlc_pkg::PW-1]};
    assign ty = {d_r[g].ry[vlc_pkg::CW-1:0], d_r[g].ny_q[vlc_pkg::PW-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[g+1].it    <= d_r[g].it;
        d_r[g+1].len   <= d_r[g].len;
        d_r[g+1].div   <= d_r[g].div;
        d_r[g+1].clamp <= d_r[g].clamp;
        if (d_r[g].div) begin
          if (tx >= {1'b0, d_r[g].len}) begin
            d_r[g+1].rx   <= tx - {1'b0, d_r[g].len};
            d_r[g+1].nx_q <= {d_r[g].nx_q[vlc_pkg::PW-2:0], 1'b1};
          end else begin
            d_r[g+1].rx   <= tx;
            d_r[g+1].nx_q <= {d_r[g].nx_q[vlc_pkg::PW-2:0], 1'b0};
          end
          if (ty >= {1'b0, d_r[g].len}) begin
            d_r[g+1].ry   <= ty - {1'b0, d_r[g].len};
            d_r[g+1].ny_q <= {d_r[g].ny_q[vlc_pkg::PW-2:0], 1'b1};
          end else begin
            d_r[g+1].ry   <= ty;
            d_r[g+1].ny_q <= {d_r[g].ny_q[vlc_pkg::PW-2:0], 1'b0};
          end
        end else begin
          d_r[g+1].rx   <= d_r[g].rx;
          d_r[g+1].ry   <= d_r[g].ry;
          d_r[g+1].nx_q <= d_r[g].nx_q;
          d_r[g+1].ny_q <= d_r[g].ny_q;
        end
      end
    end
  end

  // Result select and saturation
  dv_stage_t e;
  logic [vlc_pkg::PW-1:0] mx, my;
  assign e = d_r[NQ];
  always_comb begin
    mx = vlc_pkg::PW'(e.it.ax);
    my = vlc_pkg::PW'(e.it.ay);
    if (e.it.cmd != vlc_pkg::CMD_LENGTH && e.len == '0) begin
      mx = '0;
      my = '0;
    end else if (e.div) begin
      mx = e.nx_q;
      my = e.ny_q;
    end else if (e.it.cmd == vlc_pkg::CMD_SCALE) begin
      mx = e.nx_q >> vlc_pkg::FB;
      my = e.ny_q >> vlc_pkg::FB;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= vlc_pkg::pack_out(e.it.nx, mx);
      oy_r <= vlc_pkg::pack_out(e.it.ny, my);
      ol_r <= e.len;
      oc_r <= e.clamp && e.div;
    end
  end

  `VLC_ASSERT(a_clamp_cmd, !out_valid || !out_was_clamped
    || out_length != '0, "clamp flag with zero length")
  `VLC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_x)
    && $stable(out_length), "stalled result changed")
  `VLC_ASSERT(a_ready, q_ready == (!v_r[NT-1] || out_ready), "pipe advance mismatch")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = vlc_pkg::CW;
  localparam int OW = vlc_pkg::OW;
  localparam int FB = vlc_pkg::FB;
  localparam logic [OW-1:0] SAT_MAG = OW'((64'd1 << CW) - 1);

  // One input beat
  typedef struct {
    vlc_pkg::cmd_t cmd;
    logic [CW-1:0] vx;
    logic [CW-1:0] vy;
    logic [CW-1:0] amt;
  } vec_item_t;

  // One expected result beat
  typedef struct {
    logic [OW-1:0] rx;
    logic [OW-1:0] ry;
    logic [CW-1:0] len;
    logic          clamped;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic signed [CW-1:0] in_vec_x = '0;
  logic signed [CW-1:0] in_vec_y = '0;
  logic [CW-1:0] in_amount = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OW-1:0] out_x;
  logic signed [OW-1:0] out_y;
  logic [CW-1:0] out_length;
  logic out_was_clamped;

  vec_item_t   pending_items[$];
  vec_result_t expected_results[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int cmd_seen[4];
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  vector_length_clamp dut (.*);

  always #5 clk = ~clk;

  // Floor square root, bit by bit
  function automatic logic [CW-1:0] isqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] t;
    root = 0;
    rem = n;
    for (int b = 31; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= rem) root = t;
    end
    return root[CW-1:0];
  endfunction

  function automatic logic [OW-1:0] signed_sat(input bit neg, input logic [63:0] mag);
    logic [OW-1:0] m;
    m = (mag > 64'(SAT_MAG)) ? SAT_MAG : mag[OW-1:0];
    return neg ? OW'(0) - m : m;
  endfunction

  // Predicts the result beat of one vector command
  function automatic vec_result_t predict_vector(input vec_item_t it);
    vec_result_t r;
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic [63:0] ax, ay, l, mx, my;
    bit nx, ny;
    sx = 64'(signed'(it.vx));
    sy = 64'(signed'(it.vy));
    nx = sx < 0;
    ny = sy < 0;
    ax = nx ? -sx : sx;
    ay = ny ? -sy : sy;
    l = 64'(isqrt(ax * ax + ay * ay));
    mx = ax;
    my = ay;
    r.clamped = 1'b0;
    if (it.cmd != vlc_pkg::CMD_LENGTH && l == 0) begin
      mx = 0;
      my = 0;
    end else if (it.cmd == vlc_pkg::CMD_NORM ||
                 (it.cmd == vlc_pkg::CMD_CLAMP && 64'(it.amt) < l)) begin
      mx = ax * it.amt / l;
      my = ay * it.amt / l;
      r.clamped = (it.cmd == vlc_pkg::CMD_CLAMP);
    end else if (it.cmd == vlc_pkg::CMD_SCALE) begin
      mx = (ax * it.amt) >> FB;
      my = (ay * it.amt) >> FB;
    end
    r.rx = signed_sat(nx, mx);
    r.ry = signed_sat(ny, my);
    r.len = l[CW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0h want %0h", beats_out, what, got, want);
  endtask

  function automatic void add_item(input vlc_pkg::cmd_t c, input logic [CW-1:0] x,
                                   input logic [CW-1:0] y, input logic [CW-1:0] a);
    vec_item_t it;
    it.cmd = c;
    it.vx = x;
    it.vy = y;
    it.amt = a;
    pending_items.push_back(it);
  endfunction

  // Random component: mostly full range, sometimes moderate or extremes
  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3, 4: return CW'($urandom_range(0, 2047)) - 16'd1024;
      default: return CW'($urandom);
    endcase
  endfunction

  // Driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) beats_in <= beats_in + 1;
      if ((!in_valid || in_ready) && pending_items.size() > 0 && !hold_off &&
          (calm || $urandom_range(0, 99) >= 19)) begin
        vec_item_t it;
        it = pending_items.pop_front();
        expected_results.push_back(predict_vector(it));
        cmd_seen[it.cmd]++;
        in_valid <= 1'b1;
        in_command <= it.cmd;
        in_vec_x <= it.vx;
        in_vec_y <= it.vy;
        in_amount <= it.amt;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and result-side stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        vec_result_t e;
        beats_out <= beats_out + 1;
        if (expected_results.size() == 0) begin
          errors++;
          $display("MISMATCH unexpected result beat");
        end else begin
          e = expected_results.pop_front();
          if (out_x !== e.rx) report_mismatch("out_x", 64'(out_x), 64'(e.rx));
          if (out_y !== e.ry) report_mismatch("out_y", 64'(out_y), 64'(e.ry));
          if (out_length !== e.len)
            report_mismatch("length", 64'(out_length), 64'(e.len));
          if (out_was_clamped !== e.clamped)
            report_mismatch("was_clamped", 64'(out_was_clamped), 64'(e.clamped));
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  // Stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // extremes and special cases
    add_item(vlc_pkg::CMD_LENGTH, 16'h8000, 16'h8000, 16'hffff);
    add_item(vlc_pkg::CMD_LENGTH, 16'h7fff, 16'h8000, 16'h0000);
    add_item(vlc_pkg::CMD_NORM, 16'h0000, 16'h0000, 16'h0100);
    add_item(vlc_pkg::CMD_CLAMP, 16'h0000, 16'h0000, 16'h0000);
    add_item(vlc_pkg::CMD_SCALE, 16'h0000, 16'h0000, 16'hffff);
    add_item(vlc_pkg::CMD_NORM, 16'h0300, 16'hfc00, 16'h0100);
    add_item(vlc_pkg::CMD_NORM, 16'h8000, 16'h7fff, 16'hffff);
    add_item(vlc_pkg::CMD_CLAMP, 16'h0003, 16'h0004, 16'h0005);
    add_item(vlc_pkg::CMD_CLAMP, 16'h0003, 16'h0004, 16'h0004);
    add_item(vlc_pkg::CMD_CLAMP, 16'hfffd, 16'hfffc, 16'h0006);
    add_item(vlc_pkg::CMD_CLAMP, 16'h8000, 16'h8000, 16'h0000);
    add_item(vlc_pkg::CMD_SCALE, 16'h7fff, 16'h8000, 16'hffff);
    add_item(vlc_pkg::CMD_SCALE, 16'h0100, 16'hff00, 16'h0200);
    add_item(vlc_pkg::CMD_SCALE, 16'h0001, 16'hffff, 16'h0001);
    add_item(vlc_pkg::CMD_LENGTH, 16'hffff, 16'h0001, 16'h5555);
    add_item(vlc_pkg::CMD_NORM, 16'h0001, 16'h0000, 16'haaaa);
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    // sender holds off while the next items are queued, then releases them
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++)
      add_item(vlc_pkg::cmd_t'(i % 4), rand_comp(), rand_comp(), CW'($urandom));
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
    // random items, a calm stretch in the middle
    for (int i = 0; i < 480; i++) begin
      logic [CW-1:0] a;
      if (i == 200) begin
        wait (pending_items.size() == 0);
        calm = 1'b1;
      end
      if (i == 300) begin
        wait (pending_items.size() == 0);
        calm = 1'b0;
      end
      a = ($urandom_range(0, 3) == 0) ? CW'($urandom_range(0, 1024)) : CW'($urandom);
      add_item(vlc_pkg::cmd_t'($urandom_range(0, 3)), rand_comp(), rand_comp(), a);
    end
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (80) @(posedge clk);
    $display("Ran %0d vectors: %0d length, %0d normalize, %0d clamp, %0d scale",
             beats_in, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("Checked %0d result beats with random stalls on both sides", beats_out);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
